FILE: sv/assert_macros.svh
// Assertion macros for the RTL files; sgqt_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SGQT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SGQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SGQT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SGQT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/sgqt_pkg.sv
package sgqt_pkg;

    localparam int ANGLE_STEPS = 256;
    localparam int ANGLE_W     = 8;
    localparam int ANGLE_HALF    = ANGLE_STEPS / 2;
    localparam int ANGLE_QUARTER = ANGLE_STEPS / 4;
    localparam real ANGLE_RAD  = 2.0 * 3.14159265358979323846 / real'(ANGLE_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 10;
    localparam int MODE_STRETCH_BIT = 8;
    localparam int MODE_ROTATE_BIT  = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROUP_ORIGIN    = 3'd0,
        REG_GROUP_SIZE      = 3'd1,
        REG_CORNER_TL       = 3'd2,
        REG_CORNER_TR       = 3'd3,
        REG_CORNER_BR       = 3'd4,
        REG_CORNER_BL       = 3'd5,
        REG_ROTATION_PIVOT  = 3'd6,
        REG_TRANSFORM_MODE  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [15:0] cel_offset_x;
        logic signed [15:0] cel_offset_y;
        logic [10:0]        cel_width;
        logic [10:0]        cel_height;
        logic               last_cel;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_left_x;
        logic signed [31:0] top_left_y;
        logic signed [31:0] top_right_x;
        logic signed [31:0] top_right_y;
        logic signed [31:0] bottom_right_x;
        logic signed [31:0] bottom_right_y;
        logic signed [31:0] bottom_left_x;
        logic signed [31:0] bottom_left_y;
        logic               last_out;
    } t_out_item;

    // Local corner coordinates, integer pixels, low 16 bits
    typedef struct packed {
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
        logic        last;
    } t_qitem;

    typedef struct packed {
        logic [31:0]       origin;
        logic [31:0]       tl;
        logic [31:0]       tr;
        logic [31:0]       br;
        logic [31:0]       bl;
        logic [31:0]       pivot;
        logic [MODE_W-1:0] mode;
    } t_xf_cfg;

    typedef logic [31:0] t_sin_tab [ANGLE_STEPS];

    // Round sin(2*pi*k/steps) * 65536, folded onto the first quarter
    function automatic t_sin_tab f_build_sin();
        t_sin_tab tab;
        int       a;
        int       v;
        bit       neg;
        real      ang;
        for (int k = 0; k < ANGLE_STEPS; k++) begin
            a   = k;
            neg = 1'b0;
            if (a >= ANGLE_HALF) begin
                neg = 1'b1;
                a   = a - ANGLE_HALF;
            end
            if (a > ANGLE_QUARTER) begin
                a = ANGLE_HALF - a;
            end
            ang = real'(a) * ANGLE_RAD;
            v   = int'($sin(ang) * 65536.0);
            tab[k] = neg ? 32'(-v) : 32'(v);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_sin();

endpackage

FILE: sv/sgqt_front.sv
module sgqt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sgqt_pkg::t_in_item i_in,
    input  logic              i_size_we,
    input  logic [31:0]       i_size,
    output logic [16:0]       o_inv_w,
    output logic [16:0]       o_inv_h,
    output logic              o_push,
    output sgqt_pkg::t_qitem  o_qitem,
    input  logic              i_q_full
);
    import sgqt_pkg::*;

    logic        r_busy;
    logic [4:0]  r_step;
    logic [15:0] r_dw, r_dh;
    logic [15:0] r_rem_w, r_rem_h;
    logic [16:0] r_q_w, r_q_h;
    logic        dbit;
    logic [16:0] trial_w, trial_h;
    logic        ge_w, ge_h;

    // Restoring divide of 1.0 by each group size, one quotient bit a cycle
    assign dbit    = (r_step == 5'd16);
    assign trial_w = {r_rem_w, dbit};
    assign trial_h = {r_rem_h, dbit};
    assign ge_w    = trial_w >= {1'b0, r_dw};
    assign ge_h    = trial_h >= {1'b0, r_dh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_q_w  <= 17'h10000;
            r_q_h  <= 17'h10000;
        end else if (i_size_we) begin
            r_busy  <= 1'b1;
            r_step  <= 5'd16;
            r_dw    <= (i_size[15:0] == '0) ? 16'd1 : i_size[15:0];
            r_dh    <= (i_size[31:16] == '0) ? 16'd1 : i_size[31:16];
            r_rem_w <= '0;
            r_rem_h <= '0;
            r_q_w   <= '0;
            r_q_h   <= '0;
        end else if (r_busy) begin
            r_rem_w <= ge_w ? 16'(trial_w - {1'b0, r_dw}) : trial_w[15:0];
            r_rem_h <= ge_h ? 16'(trial_h - {1'b0, r_dh}) : trial_h[15:0];
            r_q_w   <= {r_q_w[15:0], ge_w};
            r_q_h   <= {r_q_h[15:0], ge_h};
            r_step  <= r_step - 5'd1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_inv_w = r_q_w;
    assign o_inv_h = r_q_h;

    // Accept a word and form its local corners
    assign o_ready = !r_busy && !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_qitem.x0   = i_in.cel_offset_x;
        o_qitem.x1   = 16'(i_in.cel_offset_x + {5'b0, i_in.cel_width});
        o_qitem.y0   = i_in.cel_offset_y;
        o_qitem.y1   = 16'(i_in.cel_offset_y + {5'b0, i_in.cel_height});
        o_qitem.last = i_in.last_cel;
    end

endmodule

FILE: sv/sgqt_queue.sv
module sgqt_queue #(
    parameter int DEPTH = sgqt_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sgqt_pkg::t_qitem i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output sgqt_pkg::t_qitem o_data
);
    import sgqt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem          r_mem [DEPTH];
    logic [IW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

FILE: sv/sgqt_back.sv
`include "assert_macros.svh"
module sgqt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sgqt_pkg::t_xf_cfg  i_cfg,
    input  logic [16:0]        i_inv_w,
    input  logic [16:0]        i_inv_h,
    input  logic               i_q_valid,
    input  sgqt_pkg::t_qitem   i_q_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output sgqt_pkg::t_out_item o_out
);
    import sgqt_pkg::*;

    // 16.16 multiply, floor shift, low 32 bits kept
    function automatic logic [31:0] f_mul_f16(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return p[47:16];
    endfunction

    logic        en, issue;
    logic [1:0]  r_corner;
    logic        stretch, rotate;
    logic [15:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic [31:0] pvx, pvy, posx, posy, sn, cs;
    logic [ANGLE_W-1:0] ang, ang_c;
    logic [15:0] lx, ly;
    logic [31:0] u_w, v_w;

    logic        r1_valid, r1_last;
    logic [1:0]  r1_corner;
    logic [31:0] r1_u, r1_v;
    logic [15:0] r1_lx, r1_ly;

    logic        r2_valid, r2_last;
    logic [1:0]  r2_corner;
    logic [31:0] r2_uv, r2_bux, r2_cvx, r2_buy, r2_cvy;
    logic [15:0] r2_lx, r2_ly;

    logic        r3_valid, r3_last;
    logic [1:0]  r3_corner;
    logic [31:0] r3_px, r3_py;

    logic        r4_valid, r4_last;
    logic [1:0]  r4_corner;
    logic [31:0] r4_cdx, r4_sdy, r4_sdx, r4_cdy, r4_px, r4_py;

    logic [31:0] ddx, ddy, rx, ry, fx, fy;
    logic [31:0] r_asm [6];
    logic        r_out_valid;
    t_out_item   r_out;

    // Coefficients that follow from configuration
    assign stretch = i_cfg.mode[MODE_STRETCH_BIT];
    assign rotate  = i_cfg.mode[MODE_ROTATE_BIT];
    assign ax = i_cfg.tl[15:0];
    assign ay = i_cfg.tl[31:16];
    assign bx = i_cfg.tr[15:0] - i_cfg.tl[15:0];
    assign by = i_cfg.tr[31:16] - i_cfg.tl[31:16];
    assign cx = i_cfg.bl[15:0] - i_cfg.tl[15:0];
    assign cy = i_cfg.bl[31:16] - i_cfg.tl[31:16];
    assign dx = i_cfg.tl[15:0] + i_cfg.br[15:0] - i_cfg.tr[15:0] - i_cfg.bl[15:0];
    assign dy = i_cfg.tl[31:16] + i_cfg.br[31:16] - i_cfg.tr[31:16] - i_cfg.bl[31:16];
    assign pvx  = {16'(i_cfg.pivot[15:0] - i_cfg.origin[15:0]), 16'b0};
    assign pvy  = {16'(i_cfg.pivot[31:16] - i_cfg.origin[31:16]), 16'b0};
    assign posx = {i_cfg.origin[15:0], 16'b0};
    assign posy = {i_cfg.origin[31:16], 16'b0};
    assign ang   = i_cfg.mode[ANGLE_W-1:0];
    assign ang_c = ang + ANGLE_W'(ANGLE_QUARTER);
    assign sn    = SIN_TAB[ang];
    assign cs    = SIN_TAB[ang_c];

    // Hold the whole pipe while the result waits
    assign en    = !(r_out_valid && !i_ready);
    assign issue = en && i_q_valid;
    assign o_pop = issue && (r_corner == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
        end else if (issue) begin
            r_corner <= r_corner + 2'd1;
        end
    end

    // Pick the corner and scale into the unit square
    assign lx  = (r_corner == 2'd1 || r_corner == 2'd2) ? i_q_item.x1 : i_q_item.x0;
    assign ly  = r_corner[1] ? i_q_item.y1 : i_q_item.y0;
    assign u_w = {{16{lx[15]}}, lx} * {15'b0, i_inv_w};
    assign v_w = {{16{ly[15]}}, ly} * {15'b0, i_inv_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= issue;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Pipe payload: scale, bilinear products, sum (or local corners without stretch), rotation products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_corner <= r_corner;
            r1_last   <= i_q_item.last;
            r1_u      <= u_w;
            r1_v      <= v_w;
            r1_lx     <= lx;
            r1_ly     <= ly;

            r2_corner <= r1_corner;
            r2_last   <= r1_last;
            r2_uv     <= f_mul_f16(r1_u, r1_v);
            r2_bux    <= {{16{bx[15]}}, bx} * r1_u;
            r2_cvx    <= {{16{cx[15]}}, cx} * r1_v;
            r2_buy    <= {{16{by[15]}}, by} * r1_u;
            r2_cvy    <= {{16{cy[15]}}, cy} * r1_v;
            r2_lx     <= r1_lx;
            r2_ly     <= r1_ly;

            r3_corner <= r2_corner;
            r3_last   <= r2_last;
            if (stretch) begin
                r3_px <= {ax, 16'b0} + r2_bux + r2_cvx + {{16{dx[15]}}, dx} * r2_uv;
                r3_py <= {ay, 16'b0} + r2_buy + r2_cvy + {{16{dy[15]}}, dy} * r2_uv;
            end else begin
                r3_px <= {r2_lx, 16'b0};
                r3_py <= {r2_ly, 16'b0};
            end

            r4_corner <= r3_corner;
            r4_last   <= r3_last;
            r4_cdx    <= f_mul_f16(cs, ddx);
            r4_sdy    <= f_mul_f16(sn, ddy);
            r4_sdx    <= f_mul_f16(sn, ddx);
            r4_cdy    <= f_mul_f16(cs, ddy);
            r4_px     <= r3_px;
            r4_py     <= r3_py;
        end
    end

    assign ddx = r3_px - pvx;
    assign ddy = r3_py - pvy;

    // Finish rotation when enabled and add the origin
    assign rx = rotate ? r4_cdx - r4_sdy + pvx : r4_px;
    assign ry = rotate ? r4_sdx + r4_cdy + pvy : r4_py;
    assign fx = posx + rx;
    assign fy = posy + ry;

    // Collect corners, load the result on the last one
    always_ff @(posedge i_clk) begin
        if (en && r4_valid) begin
            case (r4_corner)
                2'd0: begin
                    r_asm[0] <= fx;
                    r_asm[1] <= fy;
                end
                2'd1: begin
                    r_asm[2] <= fx;
                    r_asm[3] <= fy;
                end
                2'd2: begin
                    r_asm[4] <= fx;
                    r_asm[5] <= fy;
                end
                default: begin
                    r_out.top_left_x     <= r_asm[0];
                    r_out.top_left_y     <= r_asm[1];
                    r_out.top_right_x    <= r_asm[2];
                    r_out.top_right_y    <= r_asm[3];
                    r_out.bottom_right_x <= r_asm[4];
                    r_out.bottom_right_y <= r_asm[5];
                    r_out.bottom_left_x  <= fx;
                    r_out.bottom_left_y  <= fy;
                    r_out.last_out       <= r4_last;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r4_valid && (r4_corner == 2'd3);
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `SGQT_ASSERT_IMPL(a_pop_has_word, i_clk, i_rst_n, o_pop, i_q_valid)
    `SGQT_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid && $stable(r_out))
    `SGQT_ASSERT_NEXT(a_out_source, i_clk, i_rst_n, !r_out_valid && !(r4_valid && r4_corner == 2'd3), !r_out_valid)

endmodule

FILE: sv/sprite_group_quad_transform.sv
// An accepted word is queued; its corners pass pipe stages r1 to r4, then r_out.
// The shared corner pipe takes one corner a cycle while the output is not stalled.
// A group_size write starts a reciprocal divide; input ready is low meanwhile.
// Reset (synchronous, active low) loads register defaults, empties queue and pipe,
// and sets both reciprocals to 1.0 with no divide pass.
module sprite_group_quad_transform #(
    parameter int QUEUE_DEPTH = sgqt_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  sgqt_pkg::t_in_item                  i_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output sgqt_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [sgqt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sgqt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sgqt_pkg::*;

    t_xf_cfg     r_cfg;
    logic        size_we;
    logic [16:0] inv_w, inv_h;
    logic        push, q_full, pop, q_valid;
    t_qitem      push_item, head_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin <= 32'd0;
            r_cfg.tl     <= 32'd0;
            r_cfg.tr     <= 32'd1;
            r_cfg.br     <= 32'd65537;
            r_cfg.bl     <= 32'd65536;
            r_cfg.pivot  <= 32'd0;
            r_cfg.mode   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GROUP_ORIGIN:   r_cfg.origin <= i_cfg_data;
                REG_CORNER_TL:      r_cfg.tl     <= i_cfg_data;
                REG_CORNER_TR:      r_cfg.tr     <= i_cfg_data;
                REG_CORNER_BR:      r_cfg.br     <= i_cfg_data;
                REG_CORNER_BL:      r_cfg.bl     <= i_cfg_data;
                REG_ROTATION_PIVOT: r_cfg.pivot  <= i_cfg_data;
                REG_TRANSFORM_MODE: r_cfg.mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Group size is not held in r_cfg; the front keeps it and its reciprocals
    assign size_we = i_cfg_we && (t_cfg_reg'(i_cfg_index) == REG_GROUP_SIZE);

    sgqt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_in     (i_in),
        .i_size_we(size_we),
        .i_size   (i_cfg_data),
        .o_inv_w  (inv_w),
        .o_inv_h  (inv_h),
        .o_push   (push),
        .o_qitem  (push_item),
        .i_q_full (q_full)
    );

    sgqt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_item),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (head_item)
    );

    sgqt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_inv_w  (inv_w),
        .i_inv_h  (inv_h),
        .i_q_valid(q_valid),
        .i_q_item (head_item),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out    (o_out)
    );

endmodule
